// File: sv/elgamal_signature_sign_verify_defines.svh
// ---------------------------------------------------------------------------
// ElGamal signature unit assertion macros
// Shared property shorthands for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef ELGAMAL_SIGNATURE_SIGN_VERIFY_DEFINES_SVH
`define ELGAMAL_SIGNATURE_SIGN_VERIFY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EGS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egs checker: same-cycle rule violated");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egs checker: next-cycle rule violated");

`endif

// File: sv/egs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ElGamal signature package
// Shared widths, register indexes and operation codes.
// ---------------------------------------------------------------------------
package egs_pkg;

  localparam int DEF_MOD_BITS = 32;
  localparam int FIELD_BITS   = 32;
  localparam int EXP_BITS     = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int MIN_MOD      = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_GENERATOR   = 2'd1,
    CFG_PRIVATE_KEY = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_SIGN   = 1'b0,
    FUNC_VERIFY = 1'b1
  } func_t;

  localparam logic [FIELD_BITS-1:0] RST_MODULUS     = 32'd4294967291;
  localparam logic [FIELD_BITS-1:0] RST_GENERATOR   = 32'd2;
  localparam logic [FIELD_BITS-1:0] RST_PRIVATE_KEY = 32'd1;

endpackage

// File: sv/egs_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Operand bit cell
// One bit of the multiplier operand row; loads in parallel, then passes its
// bit to the next cell up every cycle that shift is high.
// ---------------------------------------------------------------------------
module egs_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic prev_bit,
  output logic cell_r
);

  always_ff @(posedge clk) begin
    if (load) begin
      cell_r <= load_bit;
    end else if (shift) begin
      cell_r <= prev_bit;
    end
  end

endmodule

// File: sv/egs_mulmod.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular multiplier
// Interleaved double-and-add over a row of operand cells, MSB first, one
// multiplier bit per cycle. Operand a must be below m; b may be any value.
// ---------------------------------------------------------------------------
module egs_mulmod #(
  parameter int W  = 32,
  parameter int BW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  a,
  input  logic [BW-1:0] b,
  input  logic [W-1:0]  m,
  output logic          done,
  output logic [W-1:0]  p
);

  localparam int CNTW = $clog2(BW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    a_r;
  logic [W-1:0]    m_r;
  logic [BW-1:0]   row;
  logic [W+1:0]    sum;
  logic [W+1:0]    m1;
  logic [W+1:0]    m2;

  // Operand row: cell 0 takes in zeros, the top cell feeds the adder.
  for (genvar i = 0; i < BW; i++) begin : g_row
    egs_cell u_cell (
      .clk      (clk),
      .load     (start),
      .shift    (busy_r),
      .load_bit (b[i]),
      .prev_bit ((i == 0) ? 1'b0 : row[(i == 0) ? 0 : i-1]),
      .cell_r   (row[i])
    );
  end

  assign m1  = {2'b00, m_r};
  assign m2  = {1'b0, m_r, 1'b0};
  assign sum = {1'b0, acc_r, 1'b0} + (row[BW-1] ? {2'b00, a_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(BW);
      acc_nxt  = '0;
    end else if (busy_r) begin
      priority if (sum >= m2) begin
        acc_nxt = W'(sum - m2);
      end else if (sum >= m1) begin
        acc_nxt = W'(sum - m1);
      end else begin
        acc_nxt = W'(sum);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      a_r <= a;
      m_r <= m;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// File: sv/elgamal_signature_sign_verify.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ElGamal signature sign / verify unit
// Signs a message hash or checks a signature over a prime modulus held in
// configuration registers; results report the public key if modulus >= 3.
// ---------------------------------------------------------------------------
// Every modular product runs in the bit-serial multiplier (BW =
// max(MOD_BITS, 32)); a power takes 32 squarings plus one product per set
// exponent bit. Sign runs two powers, six products (four of them
// reductions) and the Euclid loop; verify runs four powers and three
// products.
// One transaction at a time; busy drops in the cycle the result strobe shows.
// Reset (rst_n low, synchronous) returns the sequencer to idle and the
// registers to modulus 4294967291, generator 2 and private key 1.
module elgamal_signature_sign_verify
  import egs_pkg::*;
#(
  parameter int MOD_BITS = DEF_MOD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Command channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic [FIELD_BITS-1:0]   in_message_hash,
  input  logic [FIELD_BITS-1:0]   in_nonce,
  input  logic [FIELD_BITS-1:0]   in_sig_r_in,
  input  logic [FIELD_BITS-1:0]   in_sig_s_in,
  // Result channel
  output logic                    out_valid,
  output logic [FIELD_BITS-1:0]   out_sig_r_out,
  output logic [FIELD_BITS-1:0]   out_sig_s_out,
  output logic [FIELD_BITS-1:0]   out_public_key,
  output logic                    out_valid_res,
  output logic                    out_no_inverse,
  // Configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_data
);

  localparam int W    = MOD_BITS;
  localparam int BW   = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
  localparam int CNTW = $clog2(BW + 1);

  // Sequencer: one state per step of the sign or verify program, plus the
  // two states of the shared square-and-multiply subroutine.
  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_GRED = 20'h00002,
    S_Y    = 20'h00004,
    S_R    = 20'h00008,
    S_KRED = 20'h00010,
    S_EUC  = 20'h00020,
    S_DIV  = 20'h00040,
    S_EMUL = 20'h00080,
    S_XRED = 20'h00100,
    S_XR   = 20'h00200,
    S_MRED = 20'h00400,
    S_S    = 20'h00800,
    S_RRED = 20'h01000,
    S_V1   = 20'h02000,
    S_V2   = 20'h04000,
    S_V3   = 20'h08000,
    S_V4   = 20'h10000,
    S_PSQ  = 20'h20000,
    S_PML  = 20'h40000,
    S_FIN  = 20'h80000
  } state_t;

  // Modular subtraction with both operands already reduced.
  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a,
                                           input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W-1:0] res;
    if (a >= b) begin
      res = a - b;
    end else begin
      res = m - (b - a);
    end
    return res;
  endfunction

  // Control registers.
  state_t          state_r, state_nxt;
  state_t          ret_r, ret_nxt;
  logic            wait_r, wait_nxt;
  logic            pw_done_r, pw_done_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [FIELD_BITS-1:0] cfg_mod_r, cfg_mod_nxt;
  logic [FIELD_BITS-1:0] cfg_gen_r, cfg_gen_nxt;
  logic [FIELD_BITS-1:0] cfg_key_r, cfg_key_nxt;

  // Latched transaction fields.
  logic                  func_r, func_nxt;
  logic                  degen_r, degen_nxt;
  logic [FIELD_BITS-1:0] msg_r, msg_nxt;
  logic [FIELD_BITS-1:0] k_r, k_nxt;
  logic [FIELD_BITS-1:0] rin_r, rin_nxt;
  logic [FIELD_BITS-1:0] sin_r, sin_nxt;

  // Working values, all reduced below the modulus in use.
  logic [W-1:0] g_r, g_nxt;
  logic [W-1:0] y_r, y_nxt;
  logic [W-1:0] r_r, r_nxt;
  logic [W-1:0] s_r, s_nxt;
  logic [W-1:0] r0_r, r0_nxt;
  logic [W-1:0] r1_r, r1_nxt;
  logic [W-1:0] t0_r, t0_nxt;
  logic [W-1:0] t1_r, t1_nxt;
  logic [W-1:0] dv_rem_r, dv_rem_nxt;
  logic [W-1:0] dv_quo_r, dv_quo_nxt;
  logic [W-1:0] xr_r, xr_nxt;
  logic [W-1:0] mr_r, mr_nxt;
  logic [W-1:0] rr_r, rr_nxt;
  logic [W-1:0] v1_r, v1_nxt;
  logic [W-1:0] v2_r, v2_nxt;
  logic [W-1:0] v3_r, v3_nxt;
  logic [W-1:0] pw_acc_r, pw_acc_nxt;
  logic [W-1:0] pw_base_r, pw_base_nxt;
  logic [EXP_BITS-1:0] pw_exp_r, pw_exp_nxt;
  logic         noinv_r, noinv_nxt;
  logic         vres_r, vres_nxt;

  // Output registers.
  logic [FIELD_BITS-1:0] o_r_r, o_r_nxt;
  logic [FIELD_BITS-1:0] o_s_r, o_s_nxt;
  logic [FIELD_BITS-1:0] o_y_r, o_y_nxt;
  logic                  o_v_r, o_v_nxt;
  logic                  o_n_r, o_n_nxt;

  // Multiplier hookup.
  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [BW-1:0] mul_b;
  logic [W-1:0]  mul_m;
  logic          mul_done;
  logic [W-1:0]  mul_p;

  logic [W-1:0]  q_w;
  logic [W-1:0]  n_w;
  logic [W-1:0]  tsub;
  logic [W:0]    dv_rem2;
  logic          dv_ge;
  logic          accept;

  assign q_w    = W'(cfg_mod_r);
  assign n_w    = q_w - 1'b1;
  assign tsub   = sub_mod(mr_r, xr_r, n_w);
  assign accept = start && (state_r == S_IDLE);

  // Restoring division step for the Euclid quotient, one bit per cycle.
  assign dv_rem2 = {dv_rem_r, dv_quo_r[W-1]};
  assign dv_ge   = (dv_rem2 >= {1'b0, r1_r});

  egs_mulmod #(
    .W  (W),
    .BW (BW)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mul_m),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Operand selection for the multiplier; only sampled in the launch cycle.
  // A reduction is a product with one as the first operand.
  always_comb begin
    mul_a = W'(1);
    mul_b = '0;
    mul_m = q_w;
    unique case (state_r)
      S_GRED: mul_b = BW'(cfg_gen_r);
      S_KRED: begin
        mul_b = BW'(k_r);
        mul_m = n_w;
      end
      S_EMUL: begin
        mul_a = t1_r;
        mul_b = BW'(dv_quo_r);
        mul_m = n_w;
      end
      S_XRED: begin
        mul_b = BW'(cfg_key_r);
        mul_m = n_w;
      end
      S_XR: begin
        mul_a = xr_r;
        mul_b = BW'(r_r);
        mul_m = n_w;
      end
      S_MRED: begin
        mul_b = BW'(msg_r);
        mul_m = n_w;
      end
      S_S: begin
        mul_a = t0_r;
        mul_b = BW'(tsub);
        mul_m = n_w;
      end
      S_RRED: mul_b = BW'(rin_r);
      S_V4: begin
        mul_a = v2_r;
        mul_b = BW'(v3_r);
      end
      S_PSQ: begin
        mul_a = pw_acc_r;
        mul_b = BW'(pw_acc_r);
      end
      S_PML: begin
        mul_a = pw_acc_r;
        mul_b = BW'(pw_base_r);
      end
      default: begin
        mul_a = W'(1);
        mul_b = '0;
        mul_m = q_w;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    wait_nxt      = wait_r;
    pw_done_nxt   = pw_done_r;
    out_valid_nxt = 1'b0;
    cnt_nxt       = cnt_r;
    cfg_mod_nxt   = cfg_mod_r;
    cfg_gen_nxt   = cfg_gen_r;
    cfg_key_nxt   = cfg_key_r;
    func_nxt      = func_r;
    degen_nxt     = degen_r;
    msg_nxt       = msg_r;
    k_nxt         = k_r;
    rin_nxt       = rin_r;
    sin_nxt       = sin_r;
    g_nxt         = g_r;
    y_nxt         = y_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    dv_rem_nxt    = dv_rem_r;
    dv_quo_nxt    = dv_quo_r;
    xr_nxt        = xr_r;
    mr_nxt        = mr_r;
    rr_nxt        = rr_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    v3_nxt        = v3_r;
    pw_acc_nxt    = pw_acc_r;
    pw_base_nxt   = pw_base_r;
    pw_exp_nxt    = pw_exp_r;
    noinv_nxt     = noinv_r;
    vres_nxt      = vres_r;
    o_r_nxt       = o_r_r;
    o_s_nxt       = o_s_r;
    o_y_nxt       = o_y_r;
    o_v_nxt       = o_v_r;
    o_n_nxt       = o_n_r;
    mul_start     = 1'b0;

    // Register writes must arrive only while the unit is idle; not enforced here.
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODULUS:     cfg_mod_nxt = cfg_data;
        CFG_GENERATOR:   cfg_gen_nxt = cfg_data;
        CFG_PRIVATE_KEY: cfg_key_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          msg_nxt   = in_message_hash;
          k_nxt     = in_nonce;
          rin_nxt   = in_sig_r_in;
          sin_nxt   = in_sig_s_in;
          degen_nxt = (q_w < W'(MIN_MOD));
          noinv_nxt = 1'b0;
          vres_nxt  = 1'b0;
          wait_nxt  = 1'b0;
          state_nxt = (q_w < W'(MIN_MOD)) ? S_FIN : S_GRED;
        end
      end

      // Plain products and reductions: launch, then wait for the strobe.
      S_GRED, S_KRED, S_EMUL, S_XRED, S_XR, S_MRED, S_S, S_RRED, S_V4: begin
        if (!wait_r) begin
          mul_start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (mul_done) begin
          wait_nxt = 1'b0;
          unique case (state_r)
            S_GRED: begin
              g_nxt     = mul_p;
              state_nxt = S_Y;
            end
            S_KRED: begin
              r0_nxt    = n_w;
              r1_nxt    = mul_p;
              t0_nxt    = '0;
              t1_nxt    = W'(1);
              state_nxt = S_EUC;
            end
            S_EMUL: begin
              r0_nxt    = r1_r;
              r1_nxt    = dv_rem_r;
              t0_nxt    = t1_r;
              t1_nxt    = sub_mod(t0_r, mul_p, n_w);
              state_nxt = S_EUC;
            end
            S_XRED: begin
              xr_nxt    = mul_p;
              state_nxt = S_XR;
            end
            S_XR: begin
              xr_nxt    = mul_p;
              state_nxt = S_MRED;
            end
            S_MRED: begin
              mr_nxt    = mul_p;
              state_nxt = S_S;
            end
            S_S: begin
              s_nxt     = mul_p;
              state_nxt = S_FIN;
            end
            S_RRED: begin
              rr_nxt    = mul_p;
              state_nxt = S_V1;
            end
            default: begin
              vres_nxt  = (mul_p == v1_r);
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // Powers: call the square-and-multiply subroutine, then collect.
      S_Y, S_R, S_V1, S_V2, S_V3: begin
        if (!pw_done_r) begin
          pw_acc_nxt = W'(1);
          cnt_nxt    = CNTW'(EXP_BITS);
          ret_nxt    = state_r;
          wait_nxt   = 1'b0;
          state_nxt  = S_PSQ;
          unique case (state_r)
            S_Y: begin
              pw_base_nxt = g_r;
              pw_exp_nxt  = cfg_key_r;
            end
            S_R: begin
              pw_base_nxt = g_r;
              pw_exp_nxt  = k_r;
            end
            S_V1: begin
              pw_base_nxt = g_r;
              pw_exp_nxt  = msg_r;
            end
            S_V2: begin
              pw_base_nxt = y_r;
              pw_exp_nxt  = rin_r;
            end
            default: begin
              pw_base_nxt = rr_r;
              pw_exp_nxt  = sin_r;
            end
          endcase
        end else begin
          pw_done_nxt = 1'b0;
          unique case (state_r)
            S_Y: begin
              y_nxt     = pw_acc_r;
              state_nxt = (func_r == FUNC_VERIFY) ? S_RRED : S_R;
            end
            S_R: begin
              r_nxt     = pw_acc_r;
              state_nxt = S_KRED;
            end
            S_V1: begin
              v1_nxt    = pw_acc_r;
              state_nxt = S_V2;
            end
            S_V2: begin
              v2_nxt    = pw_acc_r;
              state_nxt = S_V3;
            end
            default: begin
              v3_nxt    = pw_acc_r;
              state_nxt = S_V4;
            end
          endcase
        end
      end

      // Left-to-right exponentiation: square, then multiply on a set bit.
      S_PSQ, S_PML: begin
        if (!wait_r) begin
          mul_start = 1'b1;
          wait_nxt  = 1'b1;
        end else if (mul_done) begin
          wait_nxt   = 1'b0;
          pw_acc_nxt = mul_p;
          if ((state_r == S_PSQ) && pw_exp_r[EXP_BITS-1]) begin
            state_nxt = S_PML;
          end else begin
            pw_exp_nxt = {pw_exp_r[EXP_BITS-2:0], 1'b0};
            cnt_nxt    = cnt_r - 1'b1;
            if (cnt_r == CNTW'(1)) begin
              pw_done_nxt = 1'b1;
              state_nxt   = ret_r;
            end else begin
              state_nxt = S_PSQ;
            end
          end
        end
      end

      // Extended Euclid: stop when the remainder runs out.
      S_EUC: begin
        if (r1_r == '0) begin
          if (r0_r == W'(1)) begin
            state_nxt = S_XRED;
          end else begin
            noinv_nxt = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          wait_nxt  = 1'b0;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (!wait_r) begin
          dv_rem_nxt = '0;
          dv_quo_nxt = r0_r;
          cnt_nxt    = CNTW'(W);
          wait_nxt   = 1'b1;
        end else begin
          dv_rem_nxt = dv_ge ? W'(dv_rem2 - {1'b0, r1_r}) : W'(dv_rem2);
          dv_quo_nxt = {dv_quo_r[W-2:0], dv_ge};
          cnt_nxt    = cnt_r - 1'b1;
          if (cnt_r == CNTW'(1)) begin
            wait_nxt  = 1'b0;
            state_nxt = S_EMUL;
          end
        end
      end

      S_FIN: begin
        out_valid_nxt = 1'b1;
        if (degen_r) begin
          o_r_nxt = '0;
          o_s_nxt = '0;
          o_y_nxt = '0;
          o_v_nxt = 1'b0;
          o_n_nxt = 1'b0;
        end else begin
          o_r_nxt = (func_r == FUNC_VERIFY) ? '0 : FIELD_BITS'(r_r);
          o_s_nxt = ((func_r == FUNC_VERIFY) || noinv_r) ? '0 : FIELD_BITS'(s_r);
          o_y_nxt = FIELD_BITS'(y_r);
          o_v_nxt = vres_r;
          o_n_nxt = noinv_r;
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      wait_r      <= 1'b0;
      pw_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      cfg_mod_r   <= RST_MODULUS;
      cfg_gen_r   <= RST_GENERATOR;
      cfg_key_r   <= RST_PRIVATE_KEY;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      wait_r      <= wait_nxt;
      pw_done_r   <= pw_done_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      cfg_mod_r   <= cfg_mod_nxt;
      cfg_gen_r   <= cfg_gen_nxt;
      cfg_key_r   <= cfg_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    degen_r   <= degen_nxt;
    msg_r     <= msg_nxt;
    k_r       <= k_nxt;
    rin_r     <= rin_nxt;
    sin_r     <= sin_nxt;
    g_r       <= g_nxt;
    y_r       <= y_nxt;
    r_r       <= r_nxt;
    s_r       <= s_nxt;
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    dv_rem_r  <= dv_rem_nxt;
    dv_quo_r  <= dv_quo_nxt;
    xr_r      <= xr_nxt;
    mr_r      <= mr_nxt;
    rr_r      <= rr_nxt;
    v1_r      <= v1_nxt;
    v2_r      <= v2_nxt;
    v3_r      <= v3_nxt;
    pw_acc_r  <= pw_acc_nxt;
    pw_base_r <= pw_base_nxt;
    pw_exp_r  <= pw_exp_nxt;
    noinv_r   <= noinv_nxt;
    vres_r    <= vres_nxt;
    o_r_r     <= o_r_nxt;
    o_s_r     <= o_s_nxt;
    o_y_r     <= o_y_nxt;
    o_v_r     <= o_v_nxt;
    o_n_r     <= o_n_nxt;
  end

  // The register file always takes a write; the channel never stalls.
  assign cfg_ready      = 1'b1;
  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sig_r_out  = o_r_r;
  assign out_sig_s_out  = o_s_r;
  assign out_public_key = o_y_r;
  assign out_valid_res  = o_v_r;
  assign out_no_inverse = o_n_r;

endmodule

// File: sv/egs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ElGamal signature port checker
// Watches the top-level ports and flags results that break the transaction
// rules of the unit.
// ---------------------------------------------------------------------------
`include "elgamal_signature_sign_verify_defines.svh"

module egs_checker
  import egs_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [FIELD_BITS-1:0]   out_sig_r_out,
  input logic [FIELD_BITS-1:0]   out_sig_s_out,
  input logic                    out_valid_res,
  input logic                    out_no_inverse
);

  // An accepted transaction always makes the unit busy in the following cycle.
  `EGS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only follows a busy cycle.
  `EGS_ASSERT_IMPL(a_result_after_busy, out_valid, $past(busy))
  // Results never come back to back.
  `EGS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // A passed verify carries no signature parts.
  `EGS_ASSERT_IMPL(a_verify_clean, out_valid && out_valid_res,
                   (out_sig_r_out == '0) && (out_sig_s_out == '0) && !out_no_inverse)
  // A nonce without inverse leaves s empty.
  `EGS_ASSERT_IMPL(a_noinv_clean, out_valid && out_no_inverse,
                   (out_sig_s_out == '0) && !out_valid_res)

endmodule

bind elgamal_signature_sign_verify egs_checker u_egs_checker (.*);
